@@ rtl/pid_dbaw_pkg.sv @@
// ----------------------------------------------------------------------------
// pid_dbaw_pkg
// Shared types and constants of the PID controller with deadband and
// integral anti-windup.
// ----------------------------------------------------------------------------
`default_nettype none

package pid_dbaw_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_MUL_P,
        S_MUL_I,
        S_MUL_K,
        S_DIV_B,
        S_DCHK,
        S_DIV_D,
        S_MUL_D,
        S_FIN,
        S_DONE
    } pid_state_t;

    // configuration register indexes
    localparam logic [2:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [2:0] CFG_INTEG_GAIN = 3'd1;
    localparam logic [2:0] CFG_DERIV_GAIN = 3'd2;
    localparam logic [2:0] CFG_OUT_LOW    = 3'd3;
    localparam logic [2:0] CFG_OUT_HIGH   = 3'd4;
    localparam logic [2:0] CFG_DEADBAND   = 3'd5;

    // request kinds
    localparam logic REQ_STEP  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // limit status codes
    localparam logic [1:0] LIM_NONE = 2'd0;
    localparam logic [1:0] LIM_HIGH = 2'd1;
    localparam logic [1:0] LIM_LOW  = 2'd2;

    localparam logic signed [31:0] OUT_LOW_RESET  = -32'sd6553600;
    localparam logic signed [31:0] OUT_HIGH_RESET = 32'sd6553600;

    // derivative term only for time steps above this (0.0001 s)
    localparam logic [15:0] TSTEP_MIN_EXCL = 16'd6;

    localparam int MUL_STEPS  = 32;
    localparam int DIVB_STEPS = 64;
    localparam int DIVD_STEPS = 49;

endpackage

`default_nettype wire

@@ rtl/pid_deadband_antiwindup.sv @@
// ----------------------------------------------------------------------------
// pid_deadband_antiwindup
// Fixed-point PID step with deadband, back-calculation anti-windup, gated
// derivative term and feedforward, built on a bit-serial multiplier and a
// bit-serial restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

// One item is worked on at a time. A clear request skips the arithmetic and
// goes straight to the result. A control step always runs the P, I and K
// products; it adds the anti-windup division when the P+I sum is clamped
// with a non-zero integral gain, and the derivative division and product
// when time_step is above 6. The step is built on the shared shift-add
// multiplier, which takes one multiplier bit per cycle (three or four
// products a step), and on the restoring divider, which yields one quotient
// bit per cycle. A new item is taken as soon as the previous result has been
// placed in the output register, even while that result still waits for
// m_tready.

module pid_deadband_antiwindup
    import pid_dbaw_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // slave side
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // target_value[31:0], measured_value[63:32], time_step[79:64],
    // feed_forward[111:80]
    input  wire logic [111:0] s_tdata,
    // req_type[0]
    input  wire logic [0:0]   s_tuser,
    // master side
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // drive_value[31:0], limit_status[33:32], zero[39:34]
    output logic [39:0]       m_tdata,
    // configuration
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    pid_state_t state_reg, state_next;

    logic signed [31:0] kp_reg, ki_reg, kd_reg, lo_reg, hi_reg;
    logic [30:0]        db_reg;

    logic               clr_reg, clr_next;
    logic signed [31:0] tgt_reg, tgt_next, meas_reg, meas_next, ff_reg, ff_next;
    logic [15:0]        dt_reg, dt_next;

    logic signed [47:0] integ_reg, integ_next;
    logic signed [31:0] last_reg, last_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [47:0] p_reg, p_next;
    logic signed [31:0] sum_reg, sum_next;
    logic signed [65:0] tot_reg, tot_next;

    logic signed [80:0] acc_reg, acc_next;
    logic signed [48:0] mula_reg, mula_next;
    logic [31:0]        mulb_reg, mulb_next;
    logic [5:0]         cnt_reg, cnt_next;

    logic [63:0]        dvd_reg, dvd_next;
    logic [31:0]        dvs_reg, dvs_next;
    logic [31:0]        rem_reg, rem_next;
    logic [63:0]        quo_reg, quo_next;
    logic               neg_reg, neg_next;

    logic signed [31:0] rdrv_reg, rdrv_next;
    logic [1:0]         rst_reg, rst_next;
    logic               ov_reg, ov_next;
    logic signed [31:0] odrv_reg, odrv_next;
    logic [1:0]         ost_reg, ost_next;

    // shared datapath terms
    logic signed [80:0] addend, acc_step;
    logic signed [64:0] prod_sh;
    logic [32:0]        rem_sh;
    logic               qbit;
    logic [63:0]        qmag;
    logic signed [64:0] qsgn;
    logic               out_load;

    function automatic logic signed [47:0] sat48(input logic signed [65:0] x);
        if (x[65:47] == {19{x[47]}})
        begin
            return x[47:0];
        end
        else if (x[65])
        begin
            return {1'b1, 47'b0};
        end
        else
        begin
            return {1'b0, {47{1'b1}}};
        end
    endfunction

    // bit-serial multiplier: MSB first, the sign bit carries negative weight
    always_comb
    begin
        addend = '0;
        if (mulb_reg[31])
        begin
            addend = (cnt_reg == 6'(MUL_STEPS - 1)) ? -81'(mula_reg) : 81'(mula_reg);
        end
        acc_step = (acc_reg <<< 1) + addend;
        prod_sh  = acc_step[80:16];
    end

    // restoring divider: one quotient bit per cycle
    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[63]};
        qbit   = (rem_sh >= {1'b0, dvs_reg});
        qmag   = {quo_reg[62:0], qbit};
        qsgn   = neg_reg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    end

    assign out_load = (state_reg == S_DONE) && (!ov_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                state_next = (clr_reg == REQ_CLEAR) ? S_DONE : S_MUL_P;
            end
            S_MUL_P:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_MUL_I;
                end
            end
            S_MUL_I:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_MUL_K;
                end
            end
            S_MUL_K:
            begin
                if (cnt_reg == '0)
                begin
                    if (ki_reg != '0 &&
                        ((66'(p_reg) + 66'(prod_sh)) > 66'(hi_reg) ||
                         (66'(p_reg) + 66'(prod_sh)) < 66'(lo_reg)))
                    begin
                        state_next = S_DIV_B;
                    end
                    else
                    begin
                        state_next = S_DCHK;
                    end
                end
            end
            S_DIV_B:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_DCHK;
                end
            end
            S_DCHK:
            begin
                state_next = (dt_reg > TSTEP_MIN_EXCL) ? S_DIV_D : S_FIN;
            end
            S_DIV_D:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_MUL_D;
                end
            end
            S_MUL_D:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        logic signed [32:0] diff;
        logic [32:0]        dmag;
        logic signed [31:0] esat;
        logic signed [65:0] s66;
        logic signed [31:0] lim;
        logic signed [49:0] bx;
        logic [49:0]        bmag;
        logic signed [65:0] t1;
        logic signed [31:0] drv1, drv2;
        logic signed [32:0] t2;
        logic [1:0]         st1, st2;

        clr_next   = clr_reg;
        tgt_next   = tgt_reg;
        meas_next  = meas_reg;
        ff_next    = ff_reg;
        dt_next    = dt_reg;
        integ_next = integ_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        p_next     = p_reg;
        sum_next   = sum_reg;
        tot_next   = tot_reg;
        acc_next   = acc_reg;
        mula_next  = mula_reg;
        mulb_next  = mulb_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        neg_next   = neg_reg;
        rdrv_next  = rdrv_reg;
        rst_next   = rst_reg;

        diff = 33'(tgt_reg) - 33'(meas_reg);
        dmag = diff[32] ? (~diff + 33'd1) : diff;
        if (dmag < {2'b0, db_reg})
        begin
            esat = '0;
        end
        else if (diff[32] != diff[31])
        begin
            esat = diff[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
        end
        else
        begin
            esat = diff[31:0];
        end

        s66  = 66'(p_reg) + 66'(prod_sh);
        lim  = (s66 > 66'(hi_reg)) ? hi_reg : lo_reg;
        bx   = 50'(lim) - 50'(p_reg);
        bmag = bx[49] ? (~bx + 50'd1) : bx;

        t1 = tot_reg;
        st1 = LIM_NONE;
        drv1 = t1[31:0];
        if (t1 > 66'(hi_reg))
        begin
            drv1 = hi_reg;
            st1  = LIM_HIGH;
        end
        else if (t1 < 66'(lo_reg))
        begin
            drv1 = lo_reg;
            st1  = LIM_LOW;
        end
        t2 = 33'(drv1) + 33'(ff_reg);
        st2 = LIM_NONE;
        drv2 = t2[31:0];
        if (t2 > 33'(hi_reg))
        begin
            drv2 = hi_reg;
            st2  = LIM_HIGH;
        end
        else if (t2 < 33'(lo_reg))
        begin
            drv2 = lo_reg;
            st2  = LIM_LOW;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    clr_next  = s_tuser[0];
                    tgt_next  = s_tdata[31:0];
                    meas_next = s_tdata[63:32];
                    dt_next   = s_tdata[79:64];
                    ff_next   = s_tdata[111:80];
                end
            end
            S_ERR:
            begin
                if (clr_reg == REQ_CLEAR)
                begin
                    integ_next = '0;
                    last_next  = '0;
                    rdrv_next  = '0;
                    rst_next   = LIM_NONE;
                end
                else
                begin
                    err_next  = esat;
                    mula_next = 49'(esat);
                    mulb_next = kp_reg;
                    acc_next  = '0;
                    cnt_next  = 6'(MUL_STEPS - 1);
                end
            end
            S_MUL_P, S_MUL_I, S_MUL_K, S_MUL_D:
            begin
                acc_next  = acc_step;
                mulb_next = {mulb_reg[30:0], 1'b0};
                cnt_next  = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    acc_next = '0;
                    cnt_next = 6'(MUL_STEPS - 1);
                    if (state_reg == S_MUL_P)
                    begin
                        p_next    = prod_sh[47:0];
                        mula_next = 49'(err_reg);
                        mulb_next = {16'b0, dt_reg};
                    end
                    else if (state_reg == S_MUL_I)
                    begin
                        integ_next = sat48(66'(integ_reg) + 66'(prod_sh));
                        mula_next  = 49'(sat48(66'(integ_reg) + 66'(prod_sh)));
                        mulb_next  = ki_reg;
                    end
                    else if (state_reg == S_MUL_K)
                    begin
                        if (s66 > 66'(hi_reg))
                        begin
                            sum_next = hi_reg;
                        end
                        else if (s66 < 66'(lo_reg))
                        begin
                            sum_next = lo_reg;
                        end
                        else
                        begin
                            sum_next = s66[31:0];
                        end
                        // back-calculation of the integral from the limit
                        dvd_next = {1'b0, bmag[46:0], 16'b0};
                        dvs_next = ki_reg[31] ? (~ki_reg + 32'd1) : ki_reg;
                        neg_next = bx[49] ^ ki_reg[31];
                        rem_next = '0;
                        quo_next = '0;
                        cnt_next = 6'(DIVB_STEPS - 1);
                    end
                    else
                    begin
                        tot_next = 66'(sum_reg) + 66'(prod_sh);
                    end
                end
            end
            S_DIV_B, S_DIV_D:
            begin
                rem_next = qbit ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
                dvd_next = {dvd_reg[62:0], 1'b0};
                quo_next = qmag;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    if (state_reg == S_DIV_B)
                    begin
                        integ_next = sat48(66'(qsgn));
                    end
                    else
                    begin
                        mula_next = qsgn[48:0];
                        mulb_next = kd_reg;
                        acc_next  = '0;
                        cnt_next  = 6'(MUL_STEPS - 1);
                    end
                end
            end
            S_DCHK:
            begin
                // derivative: (err - last) * 2^16 / dt
                diff      = 33'(err_reg) - 33'(last_reg);
                dmag      = diff[32] ? (~diff + 33'd1) : diff;
                dvd_next  = {dmag, 31'b0};
                dvs_next  = {16'b0, dt_reg};
                neg_next  = diff[32];
                rem_next  = '0;
                quo_next  = '0;
                cnt_next  = 6'(DIVD_STEPS - 1);
                last_next = err_reg;
                tot_next  = 66'(sum_reg);
            end
            S_FIN:
            begin
                rdrv_next = drv2;
                if (st2 != LIM_NONE)
                begin
                    rst_next = st2;
                end
                else if (ff_reg != '0 && drv2 != hi_reg && drv2 != lo_reg)
                begin
                    rst_next = LIM_NONE;
                end
                else
                begin
                    rst_next = st1;
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        ov_next   = ov_reg;
        odrv_next = odrv_reg;
        ost_next  = ost_reg;
        if (out_load)
        begin
            ov_next   = 1'b1;
            odrv_next = rdrv_reg;
            ost_next  = rst_reg;
        end
        else if (m_tready)
        begin
            ov_next = 1'b0;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = {6'b0, ost_reg, odrv_reg};

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            integ_reg <= '0;
            last_reg  <= '0;
            kp_reg    <= '0;
            ki_reg    <= '0;
            kd_reg    <= '0;
            lo_reg    <= OUT_LOW_RESET;
            hi_reg    <= OUT_HIGH_RESET;
            db_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            integ_reg <= integ_next;
            last_reg  <= last_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PROP_GAIN:  kp_reg <= cfg_data;
                    CFG_INTEG_GAIN: ki_reg <= cfg_data;
                    CFG_DERIV_GAIN: kd_reg <= cfg_data;
                    CFG_OUT_LOW:    lo_reg <= cfg_data;
                    CFG_OUT_HIGH:   hi_reg <= cfg_data;
                    CFG_DEADBAND:   db_reg <= cfg_data[30:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        clr_reg  <= clr_next;
        tgt_reg  <= tgt_next;
        meas_reg <= meas_next;
        ff_reg   <= ff_next;
        dt_reg   <= dt_next;
        err_reg  <= err_next;
        p_reg    <= p_next;
        sum_reg  <= sum_next;
        tot_reg  <= tot_next;
        acc_reg  <= acc_next;
        mula_reg <= mula_next;
        mulb_reg <= mulb_next;
        cnt_reg  <= cnt_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        rdrv_reg <= rdrv_next;
        rst_reg  <= rst_next;
        odrv_reg <= odrv_next;
        ost_reg  <= ost_next;
    end

`ifndef SYNTHESIS
    // a result appears only when the sequencer hands one over
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside the hand-over state");

    // the limit status never carries the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[33:32] != 2'd3)
        else $error("invalid limit status");

    // the partial remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_B || state_reg == S_DIV_D) |-> rem_reg < dvs_reg)
        else $error("divider remainder out of range");

    // no new transaction is taken while an item is in progress
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted during computation");
`endif

endmodule

`default_nettype wire
